[hw/rtl/rbfs_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the raster bad line fetch scheduler
package rbfs_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;
  localparam int LINE_W      = 9;
  localparam int ADDR_W      = 10;
  localparam int COL_W       = 6;
  localparam int STOLEN_W    = 7;
  localparam int TIME_OUT_W  = 32;
  localparam int DELTA_W     = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_SCROLL_Y   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_LINES_EN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DMA_FIRST_LINE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DMA_LAST_LINE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES_PER_FRAME = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_CYCLES     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_BASE     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_BASE      = 3'd7;

  // fetch kinds
  localparam logic [1:0] FK_NONE   = 2'd0;
  localparam logic [1:0] FK_MATRIX = 2'd1;
  localparam logic [1:0] FK_COLOR  = 2'd2;

  // line fetch done codes
  localparam logic [1:0] DONE_PLAIN  = 2'd1;
  localparam logic [1:0] DONE_MATRIX = 2'd2;

  // opcode kinds
  localparam logic [1:0] OP_BRK = 2'd0;
  localparam logic [1:0] OP_JSR = 2'd1;

  typedef struct packed {
    logic [2:0]        fine_scroll_y;
    logic              bad_lines_en;
    logic [LINE_W-1:0] dma_first_line;
    logic [LINE_W-1:0] dma_last_line;
    logic [9:0]        lines_per_frame;
    logic [7:0]        line_cycles;
    logic [ADDR_W-1:0] matrix_base;
    logic [ADDR_W-1:0] color_base;
  } cfg_t;

  // one classified event handed from front to back
  typedef struct packed {
    logic [1:0]            kind;
    logic [ADDR_W-1:0]     base;
    logic [STOLEN_W-1:0]   stolen;
    logic [TIME_OUT_W-1:0] next_time;
    logic [1:0]            code;
  } job_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_CALC,
    FS_PUSH
  } front_state_t;

endpackage

[hw/rtl/raster_badline_fetch_scheduler.sv]
`timescale 1ns / 1ps
// top level of the raster bad line fetch scheduler: configuration registers and wiring
//
// usage
//   input channel: one raster fetch event per request, taken when in_push is high
//   and in_full is low. result channel: a queue read port; while out_empty is low
//   the oldest result sits on the out_ ports and is taken when out_pop is high.
//   a matrix or color line gives TEXT_COLUMNS results, any other line gives one;
//   out_last_of_run marks the final result of an event.
//   configuration: cfg_we writes cfg_data into register cfg_index. the user must
//   write only while no request is in flight; the block does not enforce it.
// timing
//   the front end works on one request at a time (classify, overlap and multiply,
//   advance the fetch time) and takes no new one until it is pushed to the queue.
//   the back end emits one result per cycle while the receiver takes them, so a
//   fetching line occupies it for TEXT_COLUMNS results; a two-entry queue lets
//   the front end run ahead. when the receiver stalls, results wait in the output
//   register, the back end and the queue, and in_full stays high once the queue
//   is full and the front end holds a finished request.
// reset
//   synchronous, active low: fetch time cleared, registers to their defaults,
//   queue and output register empty.
module raster_badline_fetch_scheduler import rbfs_pkg::*; #(
  parameter int TEXT_COLUMNS = 40,
  parameter int ADDRESS_BITS = 10,
  parameter int CLOCK_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [LINE_W-1:0]     in_raster_line,
  input  logic                  in_line_fetch_done,
  input  logic                  in_mid_instruction,
  input  logic [CLOCK_BITS-1:0] in_cpu_time,
  input  logic [1:0]            in_opcode_kind,
  input  logic [2:0]            in_write_cycles,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [1:0]            out_fetch_kind,
  output logic [ADDR_W-1:0]     out_fetch_address,
  output logic [COL_W-1:0]      out_column_index,
  output logic [STOLEN_W-1:0]   out_stolen_cycles,
  output logic [TIME_OUT_W-1:0] out_next_fetch_time,
  output logic [1:0]            out_fetch_done_code,
  output logic                  out_last_of_run
);

  cfg_t cfg_r, cfg_nxt;
  logic q_push, q_full, q_pop, q_empty;
  job_t q_in, q_out;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FINE_SCROLL_Y:   cfg_nxt.fine_scroll_y   = cfg_data[2:0];
        CFG_BAD_LINES_EN:    cfg_nxt.bad_lines_en    = cfg_data[0];
        CFG_DMA_FIRST_LINE:  cfg_nxt.dma_first_line  = cfg_data[LINE_W-1:0];
        CFG_DMA_LAST_LINE:   cfg_nxt.dma_last_line   = cfg_data[LINE_W-1:0];
        CFG_LINES_PER_FRAME: cfg_nxt.lines_per_frame = cfg_data[9:0];
        CFG_LINE_CYCLES:     cfg_nxt.line_cycles     = cfg_data[7:0];
        CFG_MATRIX_BASE:     cfg_nxt.matrix_base     = cfg_data[ADDR_W-1:0];
        CFG_COLOR_BASE:      cfg_nxt.color_base      = cfg_data[ADDR_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fine_scroll_y   <= 3'd3;
      cfg_r.bad_lines_en    <= 1'b0;
      cfg_r.dma_first_line  <= '0;
      cfg_r.dma_last_line   <= '0;
      cfg_r.lines_per_frame <= 10'd312;
      cfg_r.line_cycles     <= 8'd57;
      cfg_r.matrix_base     <= '0;
      cfg_r.color_base      <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rbfs_front #(
    .TEXT_COLUMNS(TEXT_COLUMNS),
    .CLOCK_BITS  (CLOCK_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_raster_line    (in_raster_line),
    .in_line_fetch_done(in_line_fetch_done),
    .in_mid_instruction(in_mid_instruction),
    .in_cpu_time       (in_cpu_time),
    .in_opcode_kind    (in_opcode_kind),
    .in_write_cycles   (in_write_cycles),
    .q_push            (q_push),
    .q_data            (q_in),
    .q_full            (q_full)
  );

  rbfs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_out),
    .empty    (q_empty)
  );

  rbfs_back #(
    .TEXT_COLUMNS(TEXT_COLUMNS),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_data             (q_out),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_fetch_kind     (out_fetch_kind),
    .out_fetch_address  (out_fetch_address),
    .out_column_index   (out_column_index),
    .out_stolen_cycles  (out_stolen_cycles),
    .out_next_fetch_time(out_next_fetch_time),
    .out_fetch_done_code(out_fetch_done_code),
    .out_last_of_run    (out_last_of_run)
  );

endmodule

[hw/rtl/rbfs_front.sv]
`timescale 1ns / 1ps
// front end: classifies an event, works out stolen cycles and advances the fetch time
module rbfs_front import rbfs_pkg::*; #(
  parameter int TEXT_COLUMNS = 40,
  parameter int CLOCK_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [LINE_W-1:0]     in_raster_line,
  input  logic                  in_line_fetch_done,
  input  logic                  in_mid_instruction,
  input  logic [CLOCK_BITS-1:0] in_cpu_time,
  input  logic [1:0]            in_opcode_kind,
  input  logic [2:0]            in_write_cycles,
  output logic                  q_push,
  output job_t                  q_data,
  input  logic                  q_full
);

  localparam int FULL_STEAL = (TEXT_COLUMNS + 3) * 2;

  front_state_t          state_r, state_nxt;
  logic [CLOCK_BITS-1:0] fetch_time_r, fetch_time_nxt;
  logic [CLOCK_BITS-1:0] wfirst_r, wlast_r, sub_r, prod_r;
  logic                  hit_r;
  logic signed [DELTA_W-1:0] delta_r;
  logic [1:0]            kind_r, code_r;
  logic [ADDR_W-1:0]     base_r;

  logic                  accept;
  logic [CLOCK_BITS-1:0] wfirst, wlast;
  logic signed [DELTA_W-1:0] delta;
  logic                  in_win, is_matrix, is_color;
  logic [1:0]            kind, code;
  logic [ADDR_W-1:0]     base;
  logic signed [8:0]     lc_s;
  logic signed [DELTA_W+8:0] prod_s;
  logic [CLOCK_BITS-1:0] sub_eff;
  logic [STOLEN_W-1:0]   stolen;
  logic [63:0]           time_ext;

  assign accept = in_push && !in_full;

  // write window of the last opcode
  always_comb begin
    wfirst = '0;
    wlast  = '0;
    if (in_mid_instruction) begin
      if (in_opcode_kind == OP_BRK) begin
        wfirst = in_cpu_time - CLOCK_BITS'(5);
        wlast  = in_cpu_time - CLOCK_BITS'(3);
      end else if (in_opcode_kind == OP_JSR) begin
        wfirst = in_cpu_time - CLOCK_BITS'(3);
        wlast  = in_cpu_time - CLOCK_BITS'(2);
      end else if (in_write_cycles != 3'd0) begin
        wfirst = in_cpu_time - CLOCK_BITS'(in_write_cycles);
        wlast  = in_cpu_time - CLOCK_BITS'(1);
      end
    end
  end

  // line classification
  always_comb begin
    in_win = cfg.bad_lines_en && (in_raster_line >= cfg.dma_first_line)
             && (in_raster_line <= cfg.dma_last_line);
    is_matrix = (in_raster_line[2:0] == 3'(cfg.fine_scroll_y + 3'd1));
    is_color  = (in_raster_line[2:0] == cfg.fine_scroll_y);
    kind = FK_NONE;
    base = '0;
    code = DONE_PLAIN;
    if (!in_line_fetch_done && in_win) begin
      if (is_matrix) begin
        kind = FK_MATRIX;
        base = cfg.matrix_base;
        code = DONE_MATRIX;
      end else if (is_color) begin
        kind = FK_COLOR;
        base = cfg.color_base;
      end
    end
  end

  // lines until the next fetch event, may go negative with odd frame sizes
  always_comb begin
    if (in_raster_line < cfg.dma_first_line) begin
      delta = DELTA_W'(cfg.dma_first_line) - DELTA_W'(in_raster_line);
    end else if (in_raster_line >= cfg.dma_last_line) begin
      delta = DELTA_W'(cfg.lines_per_frame) - DELTA_W'(in_raster_line)
              + DELTA_W'(cfg.dma_first_line);
    end else begin
      delta = DELTA_W'(1);
    end
  end

  assign lc_s   = $signed({1'b0, cfg.line_cycles});
  assign prod_s = delta_r * lc_s;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_IDLE: if (accept) state_nxt = FS_CALC;
      FS_CALC: state_nxt = FS_PUSH;
      FS_PUSH: if (!q_full) state_nxt = FS_IDLE;
      default: state_nxt = FS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_full = 1'b1;
    q_push  = 1'b0;
    unique case (state_r)
      FS_IDLE: in_full = 1'b0;
      FS_CALC: in_full = 1'b1;
      FS_PUSH: q_push  = !q_full;
      default: in_full = 1'b1;
    endcase
  end

  always_comb begin
    sub_eff = hit_r ? sub_r : '0;
    if (kind_r == FK_NONE || sub_eff >= CLOCK_BITS'(FULL_STEAL)) begin
      stolen = '0;
    end else begin
      stolen = STOLEN_W'(8'(FULL_STEAL) - 8'(sub_eff));
    end
    fetch_time_nxt = q_push ? (fetch_time_r + prod_r) : fetch_time_r;
    time_ext = 64'(fetch_time_nxt);
    q_data.kind      = kind_r;
    q_data.base      = base_r;
    q_data.stolen    = stolen;
    q_data.next_time = time_ext[TIME_OUT_W-1:0];
    q_data.code      = code_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FS_IDLE;
      fetch_time_r <= '0;
    end else begin
      state_r      <= state_nxt;
      fetch_time_r <= fetch_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wfirst_r <= wfirst;
      wlast_r  <= wlast;
      delta_r  <= delta;
      kind_r   <= kind;
      base_r   <= base;
      code_r   <= code;
    end
    if (state_r == FS_CALC) begin
      hit_r  <= (fetch_time_r >= wfirst_r) && (fetch_time_r <= wlast_r);
      sub_r  <= wlast_r - fetch_time_r + CLOCK_BITS'(1);
      prod_r <= CLOCK_BITS'(prod_s);
    end
  end

endmodule

[hw/rtl/rbfs_queue.sv]
`timescale 1ns / 1ps
// two-entry queue of classified events between front and back
module rbfs_queue import rbfs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic empty
);

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

[hw/rtl/rbfs_back.sv]
`timescale 1ns / 1ps
// back end: walks the text columns of one event and drives the result register
module rbfs_back import rbfs_pkg::*; #(
  parameter int TEXT_COLUMNS = 40,
  parameter int ADDRESS_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  job_t                  q_data,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [1:0]            out_fetch_kind,
  output logic [ADDR_W-1:0]     out_fetch_address,
  output logic [COL_W-1:0]      out_column_index,
  output logic [STOLEN_W-1:0]   out_stolen_cycles,
  output logic [TIME_OUT_W-1:0] out_next_fetch_time,
  output logic [1:0]            out_fetch_done_code,
  output logic                  out_last_of_run
);

  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((1 << ADDRESS_BITS) - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(TEXT_COLUMNS - 1);

  job_t             job_r;
  logic             act_r, act_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic              out_ready, emit, last_col, job_done;
  logic [ADDR_W-1:0] addr;

  assign out_ready = !out_valid_r || out_pop;
  assign emit      = act_r && out_ready;
  assign last_col  = (job_r.kind == FK_NONE) || (col_r == LAST_COL);
  assign job_done  = emit && last_col;
  assign q_pop     = !q_empty && (!act_r || job_done);
  assign addr      = (job_r.kind == FK_NONE) ? '0
                     : ((job_r.base + ADDR_W'(col_r)) & ADDR_MASK);
  assign out_empty = !out_valid_r;

  always_comb begin
    act_nxt       = act_r;
    col_nxt       = col_r;
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      act_nxt = 1'b1;
      col_nxt = '0;
    end else if (job_done) begin
      act_nxt = 1'b0;
    end else if (emit) begin
      col_nxt = col_r + COL_W'(1);
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_data;
    if (emit) begin
      out_fetch_kind      <= job_r.kind;
      out_fetch_address   <= addr;
      out_column_index    <= (job_r.kind == FK_NONE) ? '0 : col_r;
      out_stolen_cycles   <= job_r.stolen;
      out_next_fetch_time <= job_r.next_time;
      out_fetch_done_code <= job_r.code;
      out_last_of_run     <= last_col;
    end
  end

endmodule

[sim/raster_badline_fetch_scheduler_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench of the raster bad line fetch scheduler
module raster_badline_fetch_scheduler_tb;
  import rbfs_pkg::*;

  localparam int COLUMNS        = 40;
  localparam int FULL_STEAL     = (COLUMNS + 3) * 2;
  localparam int TOTAL_REQUESTS = 450;
  localparam logic [1:0] OP_OTHER = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [LINE_W-1:0] raster_line;
    logic              line_fetch_done;
    logic              mid_instruction;
    logic [31:0]       cpu_time;
    logic [1:0]        opcode_kind;
    logic [2:0]        write_cycles;
  } fetch_event_t;

  typedef struct {
    logic [1:0]            fetch_kind;
    logic [ADDR_W-1:0]     fetch_address;
    logic [COL_W-1:0]      column_index;
    logic [STOLEN_W-1:0]   stolen_cycles;
    logic [TIME_OUT_W-1:0] next_fetch_time;
    logic [1:0]            fetch_done_code;
    logic                  last_of_run;
  } fetch_result_t;

  class fetch_scoreboard;
    cfg_t            regs;
    logic [31:0]     fetch_time;
    fetch_result_t   expected_q[$];
    int              n_requests;
    int              n_results;
    int              n_fail;
    int              n_matrix;
    int              n_color;

    function new();
      regs = '0;
      regs.fine_scroll_y   = 3'd3;
      regs.lines_per_frame = 10'd312;
      regs.line_cycles     = 8'd57;
      fetch_time = '0;
      n_requests = 0;
      n_results  = 0;
      n_fail     = 0;
      n_matrix   = 0;
      n_color    = 0;
    endfunction

    function void set_register(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FINE_SCROLL_Y:   regs.fine_scroll_y   = data[2:0];
        CFG_BAD_LINES_EN:    regs.bad_lines_en    = data[0];
        CFG_DMA_FIRST_LINE:  regs.dma_first_line  = data[LINE_W-1:0];
        CFG_DMA_LAST_LINE:   regs.dma_last_line   = data[LINE_W-1:0];
        CFG_LINES_PER_FRAME: regs.lines_per_frame = data[9:0];
        CFG_LINE_CYCLES:     regs.line_cycles     = data[7:0];
        CFG_MATRIX_BASE:     regs.matrix_base     = data[ADDR_W-1:0];
        CFG_COLOR_BASE:      regs.color_base      = data[ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // works out the fetch results of one accepted request and advances the fetch time
    function void note_request(input fetch_event_t r);
      logic [31:0]         wfirst, wlast, overlap, span;
      logic [STOLEN_W-1:0] stolen;
      logic [1:0]          kind, code;
      logic [ADDR_W-1:0]   base;
      logic [2:0]          matrix_bits;
      logic                in_dma;
      fetch_result_t       res;
      int                  n;
      wfirst = '0;
      wlast = '0;
      overlap = '0;
      stolen = '0;
      kind = FK_NONE;
      code = DONE_PLAIN;
      base = '0;
      if (r.mid_instruction) begin
        if (r.opcode_kind == OP_BRK) begin
          wfirst = r.cpu_time - 32'd5;
          wlast  = r.cpu_time - 32'd3;
        end else if (r.opcode_kind == OP_JSR) begin
          wfirst = r.cpu_time - 32'd3;
          wlast  = r.cpu_time - 32'd2;
        end else if (r.write_cycles != 3'd0) begin
          wfirst = r.cpu_time - 32'(r.write_cycles);
          wlast  = r.cpu_time - 32'd1;
        end
      end
      // an empty window of 0..0 still overlaps a fetch time of zero
      if (fetch_time >= wfirst && fetch_time <= wlast) overlap = wlast - fetch_time + 32'd1;
      in_dma = regs.bad_lines_en && r.raster_line >= regs.dma_first_line
               && r.raster_line <= regs.dma_last_line;
      matrix_bits = regs.fine_scroll_y + 3'd1;
      if (!r.line_fetch_done && in_dma) begin
        if (r.raster_line[2:0] == matrix_bits) begin
          kind = FK_MATRIX;
          base = regs.matrix_base;
          code = DONE_MATRIX;
        end else if (r.raster_line[2:0] == regs.fine_scroll_y) begin
          kind = FK_COLOR;
          base = regs.color_base;
        end
      end
      if (kind != FK_NONE) stolen = (overlap >= FULL_STEAL) ? '0 : STOLEN_W'(FULL_STEAL - overlap);
      if (r.raster_line < regs.dma_first_line) begin
        span = 32'(regs.dma_first_line) - 32'(r.raster_line);
      end else if (r.raster_line >= regs.dma_last_line) begin
        span = 32'(regs.lines_per_frame) - 32'(r.raster_line) + 32'(regs.dma_first_line);
      end else begin
        span = 32'd1;
      end
      fetch_time = fetch_time + span * 32'(regs.line_cycles);
      n_requests++;
      if (kind == FK_MATRIX) n_matrix++;
      if (kind == FK_COLOR) n_color++;
      n = (kind != FK_NONE) ? COLUMNS : 1;
      for (int k = 0; k < n; k++) begin
        res.fetch_kind      = kind;
        res.fetch_address   = (kind != FK_NONE) ? ADDR_W'(base + ADDR_W'(k)) : '0;
        res.column_index    = (kind != FK_NONE) ? COL_W'(k) : '0;
        res.stolen_cycles   = stolen;
        res.next_fetch_time = fetch_time;
        res.fetch_done_code = code;
        res.last_of_run     = (k == n - 1);
        expected_q.push_back(res);
      end
    endfunction

    function void compare(input string field, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        n_fail++;
      end
    endfunction

    function void check_result(input fetch_result_t got);
      fetch_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: fetch_address %0h", got.fetch_address);
        n_fail++;
        return;
      end
      want = expected_q.pop_front();
      n_results++;
      compare("fetch_kind", 32'(want.fetch_kind), 32'(got.fetch_kind));
      compare("fetch_address", 32'(want.fetch_address), 32'(got.fetch_address));
      compare("column_index", 32'(want.column_index), 32'(got.column_index));
      compare("stolen_cycles", 32'(want.stolen_cycles), 32'(got.stolen_cycles));
      compare("next_fetch_time", 32'(want.next_fetch_time), 32'(got.next_fetch_time));
      compare("fetch_done_code", 32'(want.fetch_done_code), 32'(got.fetch_done_code));
      compare("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [LINE_W-1:0]     in_raster_line = '0;
  logic                  in_line_fetch_done = 1'b0;
  logic                  in_mid_instruction = 1'b0;
  logic [31:0]           in_cpu_time = '0;
  logic [1:0]            in_opcode_kind = '0;
  logic [2:0]            in_write_cycles = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [1:0]            out_fetch_kind;
  logic [ADDR_W-1:0]     out_fetch_address;
  logic [COL_W-1:0]      out_column_index;
  logic [STOLEN_W-1:0]   out_stolen_cycles;
  logic [TIME_OUT_W-1:0] out_next_fetch_time;
  logic [1:0]            out_fetch_done_code;
  logic                  out_last_of_run;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit rx_hold = 1'b0;
  int n_settings = 0;
  fetch_scoreboard sb;

  raster_badline_fetch_scheduler i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_raster_line      (in_raster_line),
    .in_line_fetch_done  (in_line_fetch_done),
    .in_mid_instruction  (in_mid_instruction),
    .in_cpu_time         (in_cpu_time),
    .in_opcode_kind      (in_opcode_kind),
    .in_write_cycles     (in_write_cycles),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_fetch_kind      (out_fetch_kind),
    .out_fetch_address   (out_fetch_address),
    .out_column_index    (out_column_index),
    .out_stolen_cycles   (out_stolen_cycles),
    .out_next_fetch_time (out_next_fetch_time),
    .out_fetch_done_code (out_fetch_done_code),
    .out_last_of_run     (out_last_of_run)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    sb.set_register(idx, CFG_DATA_W'(value));
  endtask

  task automatic program_settings(input int scroll, input int enable, input int first,
                                  input int last, input int frame, input int cycles,
                                  input int matrix, input int color);
    write_reg(CFG_FINE_SCROLL_Y, scroll);
    write_reg(CFG_BAD_LINES_EN, enable);
    write_reg(CFG_DMA_FIRST_LINE, first);
    write_reg(CFG_DMA_LAST_LINE, last);
    write_reg(CFG_LINES_PER_FRAME, frame);
    write_reg(CFG_LINE_CYCLES, cycles);
    write_reg(CFG_MATRIX_BASE, matrix);
    write_reg(CFG_COLOR_BASE, color);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic program_random_settings();
    int first, last, frame, cycles;
    case ($urandom_range(0, 4))
      0: begin
        first = 0;
        last  = 511;
      end
      1: begin
        first = 511;
        last  = 0;
      end
      default: begin
        first = $urandom_range(0, 300);
        last  = first + $urandom_range(0, 211);
      end
    endcase
    case ($urandom_range(0, 3))
      0: frame = 512;
      1: frame = 1;
      default: frame = $urandom_range(0, 1023);
    endcase
    case ($urandom_range(0, 3))
      0: cycles = 255;
      1: cycles = 0;
      default: cycles = $urandom_range(1, 255);
    endcase
    program_settings($urandom_range(0, 7), int'($urandom_range(0, 4) != 0), first, last,
                     frame, cycles, $urandom_range(0, 1023), $urandom_range(0, 1023));
  endtask

  // with rel set the cpu time is taken relative to the pending fetch time
  function automatic fetch_event_t make_event(input logic [LINE_W-1:0] line, input bit done,
                                              input bit mid, input bit rel,
                                              input logic [31:0] cpu,
                                              input logic [1:0] kind, input logic [2:0] wc);
    fetch_event_t ev;
    ev.raster_line     = line;
    ev.line_fetch_done = done;
    ev.mid_instruction = mid;
    ev.cpu_time        = rel ? sb.fetch_time + cpu : cpu;
    ev.opcode_kind     = kind;
    ev.write_cycles    = wc;
    return ev;
  endfunction

  function automatic fetch_event_t random_event();
    fetch_event_t ev;
    logic [2:0]   target;
    ev.raster_line = LINE_W'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      if (sb.regs.dma_first_line <= sb.regs.dma_last_line)
        ev.raster_line = LINE_W'($urandom_range(sb.regs.dma_first_line, sb.regs.dma_last_line));
      target = sb.regs.fine_scroll_y + ($urandom_range(0, 1) ? 3'd1 : 3'd0);
      // may step just outside the window near its ends
      ev.raster_line[2:0] = target;
    end
    ev.line_fetch_done = ($urandom_range(0, 7) == 0);
    ev.mid_instruction = ($urandom_range(0, 3) != 0);
    ev.cpu_time = $urandom_range(0, 1) ? $urandom : sb.fetch_time + $urandom_range(0, 8);
    ev.opcode_kind  = 2'($urandom);
    ev.write_cycles = 3'($urandom);
    return ev;
  endfunction

  task automatic send_event(input fetch_event_t ev);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_push            <= 1'b1;
    in_raster_line     <= ev.raster_line;
    in_line_fetch_done <= ev.line_fetch_done;
    in_mid_instruction <= ev.mid_instruction;
    in_cpu_time        <= ev.cpu_time;
    in_opcode_kind     <= ev.opcode_kind;
    in_write_cycles    <= ev.write_cycles;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_request(ev);
  endtask

  task automatic wait_all_results();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int sent, batch, remaining, phase;
    bit quiet;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: bad lines off, window and fetch time at zero
    send_event(make_event(9'd0, 1'b0, 1'b0, 1'b0, 32'd0, OP_BRK, 3'd0));
    send_event(make_event(9'd511, 1'b0, 1'b1, 1'b0, 32'hffff_ffff, OP_OTHER, 3'd7));
    send_event(make_event(9'd4, 1'b0, 1'b1, 1'b0, 32'd2, OP_BRK, 3'd0));
    send_event(make_event(9'd100, 1'b0, 1'b1, 1'b0, 32'd1, OP_JSR, 3'd0));
    wait_all_results();

    // scroll of 7 puts the matrix line on low bits 0
    program_settings(7, 1, 8, 500, 512, 255, 1023, 1000);
    send_event(make_event(9'd8, 1'b0, 1'b0, 1'b0, $urandom, OP_OTHER, 3'd0));
    send_event(make_event(9'd15, 1'b0, 1'b1, 1'b1, 32'd4, OP_BRK, 3'd2));
    send_event(make_event(9'd16, 1'b1, 1'b1, 1'b1, 32'd3, OP_JSR, 3'd5));
    send_event(make_event(9'd496, 1'b0, 1'b1, 1'b1, 32'd7, OP_OTHER, 3'd7));
    send_event(make_event(9'd503, 1'b0, 1'b1, 1'b1, 32'd1, OP_SPARE, 3'd7));
    send_event(make_event(9'd7, 1'b0, 1'b1, 1'b1, 32'd3, OP_JSR, 3'd3));
    send_event(make_event(9'd504, 1'b0, 1'b1, 1'b1, 32'd2, OP_JSR, 3'd0));
    send_event(make_event(9'd24, 1'b0, 1'b1, 1'b1, 32'd1, OP_SPARE, 3'd1));
    send_event(make_event(9'd31, 1'b0, 1'b1, 1'b1, 32'd0, OP_OTHER, 3'd0));
    send_event(make_event(9'd500, 1'b0, 1'b1, 1'b0, 32'hffff_fffe, OP_OTHER, 3'd6));
    wait_all_results();

    program_settings(0, 1, 0, 511, 1, 0, 0, 1023);
    send_event(make_event(9'd1, 1'b0, 1'b1, 1'b1, 32'd5, OP_BRK, 3'd4));
    send_event(make_event(9'd0, 1'b0, 1'b0, 1'b0, 32'd0, OP_OTHER, 3'd0));
    send_event(make_event(9'd511, 1'b0, 1'b1, 1'b0, 32'd3, OP_BRK, 3'd7));
    send_event(make_event(9'd504, 1'b0, 1'b1, 1'b1, 32'd6, OP_SPARE, 3'd6));
    wait_all_results();

    sent = sb.n_requests;
    phase = 0;
    while (sent < TOTAL_REQUESTS) begin
      program_random_settings();
      remaining = TOTAL_REQUESTS - sent;
      quiet = (remaining <= 60);
      batch = quiet ? remaining : $urandom_range(30, 60);
      tx_idle_on = !quiet && ($urandom_range(0, 3) != 0);
      rx_idle_on = !quiet && ($urandom_range(0, 3) != 0);
      // long receiver hold-off while requests keep coming
      if (phase == 1) rx_hold = 1'b1;
      repeat (batch) begin
        send_event(random_event());
        sent++;
      end
      wait_all_results();
      phase++;
    end

    repeat (20) @(posedge clk);
    $display("%0d raster events (%0d matrix lines, %0d color lines), %0d fetch results checked",
             sb.n_requests, sb.n_matrix, sb.n_color, sb.n_results);
    $display("%0d register settings applied, one long result stall backed up the input",
             n_settings);
    if (sb.n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    fetch_result_t got;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold) begin
        out_pop <= 1'b0;
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      if (out_empty === 1'b0) begin
        got.fetch_kind      = out_fetch_kind;
        got.fetch_address   = out_fetch_address;
        got.column_index    = out_column_index;
        got.stolen_cycles   = out_stolen_cycles;
        got.next_fetch_time = out_next_fetch_time;
        got.fetch_done_code = out_fetch_done_code;
        got.last_of_run     = out_last_of_run;
        sb.check_result(got);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
